FILE: rtl/vaar_pkg.sv
// Shared constants, types and helpers for the voxel axis-angle rotate core.
`default_nettype none

package vaar_pkg;

    // Grid geometry
    localparam int GRID_SIDE   = 64;
    localparam int GRID_HALF   = GRID_SIDE / 2;
    localparam int GRID_OFFSET = (GRID_SIDE * GRID_SIDE * GRID_SIDE) / 2
                               + (GRID_SIDE * GRID_SIDE) / 2 + GRID_SIDE / 2;

    // Field widths
    localparam int CFG_W     = 16;
    localparam int CFG_IDX_W = 3;
    localparam int COORD_W   = 6;
    localparam int VAL_W     = 2;
    localparam int IDX_OUT_W = 18;

    // Datapath widths
    localparam int Q14_FRAC = 14;              // Q1.14 fraction bits
    localparam int Q14_ONE  = 16384;
    localparam int PROD_W   = 2 * CFG_W;       // axis * axis, axis * sin
    localparam int T_W      = CFG_W + 1;       // 1 - cos
    localparam int ENT_W    = 48;              // matrix entry, Q.42
    localparam int TERM_W   = ENT_W + COORD_W; // coordinate * entry
    localparam int ACC_W    = TERM_W + 2;      // three-term dot product
    localparam int FRAC_W   = 3 * Q14_FRAC;    // Q.42
    localparam int Q_W      = ACC_W - FRAC_W;  // rounded coordinate
    localparam int IDX_W    = 40;              // linear index before masking

    // Pipeline depth of the item path
    localparam int NSTG = 5;

    // Register indexes
    localparam logic [CFG_IDX_W-1:0] REG_AXIS_X = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] REG_AXIS_Y = CFG_IDX_W'(1);
    localparam logic [CFG_IDX_W-1:0] REG_AXIS_Z = CFG_IDX_W'(2);
    localparam logic [CFG_IDX_W-1:0] REG_COS    = CFG_IDX_W'(3);
    localparam logic [CFG_IDX_W-1:0] REG_SIN    = CFG_IDX_W'(4);

    typedef logic signed [COORD_W-1:0] t_coord;
    typedef logic signed [VAL_W-1:0]   t_val;
    typedef logic signed [CFG_W-1:0]   t_cfg;
    typedef logic signed [ENT_W-1:0]   t_entry;
    typedef t_entry [2:0][2:0]         t_mat;   // [row][col]
    typedef logic signed [TERM_W-1:0]  t_term;
    typedef logic signed [ACC_W-1:0]   t_acc;
    typedef logic signed [Q_W-1:0]     t_q;

    // Per-stage data load strobes
    typedef struct packed {
        logic s1;
        logic s2;
        logic s3;
        logic s4;
        logic s5;
    } t_pipe_ctl;

    localparam t_q GRID_LO = Q_W'(-GRID_HALF);
    localparam t_q GRID_HI = Q_W'(GRID_HALF);

    function automatic logic in_grid(t_q v);
        return (v >= GRID_LO) && (v < GRID_HI);
    endfunction

endpackage

`default_nettype wire

FILE: rtl/vaar_matrix.sv
// Configuration registers and the two-stage rotation matrix builder.
`default_nettype none

module vaar_matrix
    import vaar_pkg::*;
(
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_cfg_we,
    input  wire logic [CFG_IDX_W-1:0] i_cfg_idx,
    input  wire logic [CFG_W-1:0]     i_cfg_data,
    output t_mat                      o_mat
);

    t_cfg r_ax, r_ay, r_az, r_c, r_s;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ax <= '0;
            r_ay <= '0;
            r_az <= CFG_W'(Q14_ONE);
            r_c  <= CFG_W'(Q14_ONE);
            r_s  <= '0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                REG_AXIS_X: r_ax <= i_cfg_data;
                REG_AXIS_Y: r_ay <= i_cfg_data;
                REG_AXIS_Z: r_az <= i_cfg_data;
                REG_COS:    r_c  <= i_cfg_data;
                REG_SIN:    r_s  <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // Stage M1: axis products, axis * sin, t = 1 - cos
    logic signed [PROD_W-1:0] r_pxx, r_pyy, r_pzz, r_pxy, r_pxz, r_pyz;
    logic signed [PROD_W-1:0] r_psx, r_psy, r_psz;
    logic signed [T_W-1:0]    r_t;
    t_cfg                     r_c1;

    always_ff @(posedge i_clk) begin
        r_pxx <= PROD_W'(r_ax) * PROD_W'(r_ax);
        r_pyy <= PROD_W'(r_ay) * PROD_W'(r_ay);
        r_pzz <= PROD_W'(r_az) * PROD_W'(r_az);
        r_pxy <= PROD_W'(r_ax) * PROD_W'(r_ay);
        r_pxz <= PROD_W'(r_ax) * PROD_W'(r_az);
        r_pyz <= PROD_W'(r_ay) * PROD_W'(r_az);
        r_psx <= PROD_W'(r_ax) * PROD_W'(r_s);
        r_psy <= PROD_W'(r_ay) * PROD_W'(r_s);
        r_psz <= PROD_W'(r_az) * PROD_W'(r_s);
        r_t   <= T_W'(Q14_ONE) - T_W'(r_c);
        r_c1  <= r_c;
    end

    // Stage M2: entries in Q.42
    logic signed [PROD_W+T_W-1:0] w_txx, w_tyy, w_tzz, w_txy, w_txz, w_tyz;
    t_entry w_cq, w_sx, w_sy, w_sz;
    t_mat   r_mat;

    assign w_txx = (PROD_W+T_W)'(r_pxx) * (PROD_W+T_W)'(r_t);
    assign w_tyy = (PROD_W+T_W)'(r_pyy) * (PROD_W+T_W)'(r_t);
    assign w_tzz = (PROD_W+T_W)'(r_pzz) * (PROD_W+T_W)'(r_t);
    assign w_txy = (PROD_W+T_W)'(r_pxy) * (PROD_W+T_W)'(r_t);
    assign w_txz = (PROD_W+T_W)'(r_pxz) * (PROD_W+T_W)'(r_t);
    assign w_tyz = (PROD_W+T_W)'(r_pyz) * (PROD_W+T_W)'(r_t);
    assign w_cq  = ENT_W'(r_c1) <<< (2 * Q14_FRAC);
    assign w_sx  = ENT_W'(r_psx) <<< Q14_FRAC;
    assign w_sy  = ENT_W'(r_psy) <<< Q14_FRAC;
    assign w_sz  = ENT_W'(r_psz) <<< Q14_FRAC;

    always_ff @(posedge i_clk) begin
        r_mat[0][0] <= ENT_W'(w_txx) + w_cq;
        r_mat[0][1] <= ENT_W'(w_txy) + w_sz;
        r_mat[0][2] <= ENT_W'(w_txz) - w_sy;
        r_mat[1][0] <= ENT_W'(w_txy) - w_sz;
        r_mat[1][1] <= ENT_W'(w_tyy) + w_cq;
        r_mat[1][2] <= ENT_W'(w_tyz) + w_sx;
        r_mat[2][0] <= ENT_W'(w_txz) + w_sy;
        r_mat[2][1] <= ENT_W'(w_tyz) - w_sx;
        r_mat[2][2] <= ENT_W'(w_tzz) + w_cq;
    end

    assign o_mat = r_mat;

endmodule

`default_nettype wire

FILE: rtl/vaar_rotate.sv
// Item stages 1-4: capture, source checks, coordinate products, dot products.
`default_nettype none

module vaar_rotate
    import vaar_pkg::*;
(
    input  wire logic i_clk,
    input  t_pipe_ctl i_ctl,
    input  t_coord    i_src_x,
    input  t_coord    i_src_y,
    input  t_coord    i_src_z,
    input  t_val      i_voxel_value,
    input  t_mat      i_mat,
    output t_acc [2:0] o_acc,
    output logic      o_live,
    output t_val      o_val
);

    localparam t_acc ACC_HALF = {{(ACC_W-FRAC_W){1'b0}}, 1'b1, {(FRAC_W-1){1'b0}}};

    // Stage 1: input capture
    t_coord [2:0] r_s1_c;
    t_val         r_s1_val;

    always_ff @(posedge i_clk) begin
        if (i_ctl.s1) begin
            r_s1_c   <= {i_src_z, i_src_y, i_src_x};
            r_s1_val <= i_voxel_value;
        end
    end

    // Stage 2: nonzero value and source inside grid
    t_coord [2:0] r_s2_c;
    t_val         r_s2_val;
    logic         r_s2_live;

    always_ff @(posedge i_clk) begin
        if (i_ctl.s2) begin
            r_s2_c    <= r_s1_c;
            r_s2_val  <= r_s1_val;
            r_s2_live <= (r_s1_val != '0) && in_grid(Q_W'(r_s1_c[0]))
                         && in_grid(Q_W'(r_s1_c[1])) && in_grid(Q_W'(r_s1_c[2]));
        end
    end

    // Stage 3: nine coordinate * entry products
    t_term [2:0][2:0] r_s3_p;
    t_val             r_s3_val;
    logic             r_s3_live;

    always_ff @(posedge i_clk) begin
        if (i_ctl.s3) begin
            for (int r = 0; r < 3; r++) begin
                for (int c = 0; c < 3; c++) begin
                    r_s3_p[r][c] <= TERM_W'(r_s2_c[c]) * TERM_W'(i_mat[r][c]);
                end
            end
            r_s3_val  <= r_s2_val;
            r_s3_live <= r_s2_live;
        end
    end

    // Stage 4: row sums plus one half
    t_acc [2:0] r_s4_acc;
    t_val       r_s4_val;
    logic       r_s4_live;

    always_ff @(posedge i_clk) begin
        if (i_ctl.s4) begin
            for (int r = 0; r < 3; r++) begin
                r_s4_acc[r] <= ACC_W'(r_s3_p[r][0]) + ACC_W'(r_s3_p[r][1])
                               + ACC_W'(r_s3_p[r][2]) + ACC_HALF;
            end
            r_s4_val  <= r_s3_val;
            r_s4_live <= r_s3_live;
        end
    end

    assign o_acc  = r_s4_acc;
    assign o_live = r_s4_live;
    assign o_val  = r_s4_val;

endmodule

`default_nettype wire

FILE: rtl/vaar_place.sv
// Item stage 5: rounding toward zero, destination bounds, linear index, output word.
`default_nettype none

module vaar_place
    import vaar_pkg::*;
(
    input  wire logic                 i_clk,
    input  t_pipe_ctl                 i_ctl,
    input  t_acc [2:0]                i_acc,
    input  wire logic                 i_live,
    input  t_val                      i_val,
    output t_coord                    o_dst_x,
    output t_coord                    o_dst_y,
    output t_coord                    o_dst_z,
    output logic [IDX_OUT_W-1:0]      o_dst_index,
    output t_val                      o_dst_value,
    output logic                      o_write_valid
);

    localparam logic signed [IDX_W-1:0] SIDE_L    = IDX_W'(GRID_SIDE);
    localparam logic signed [IDX_W-1:0] SIDE_SQ_L = IDX_W'(GRID_SIDE * GRID_SIDE);
    localparam logic signed [IDX_W-1:0] OFFSET_L  = IDX_W'(GRID_OFFSET);

    // Divide by 2^42, truncating toward zero
    function automatic t_q round_q(t_acc a);
        t_acc sh;
        logic bump;
        sh   = a >>> FRAC_W;
        bump = a[ACC_W-1] && (a[FRAC_W-1:0] != '0);
        return Q_W'(sh) + (bump ? Q_W'(1) : Q_W'(0));
    endfunction

    t_q                      w_qx, w_qy, w_qz;
    logic                    w_wv;
    logic signed [IDX_W-1:0] w_idx;

    assign w_qx  = round_q(i_acc[0]);
    assign w_qy  = round_q(i_acc[1]);
    assign w_qz  = round_q(i_acc[2]);
    assign w_wv  = i_live && in_grid(w_qx) && in_grid(w_qy) && in_grid(w_qz);
    assign w_idx = IDX_W'(w_qx) + IDX_W'(w_qy) * SIDE_L + IDX_W'(w_qz) * SIDE_SQ_L
                   + OFFSET_L;

    t_coord                r_dst_x, r_dst_y, r_dst_z;
    logic [IDX_OUT_W-1:0]  r_dst_index;
    t_val                  r_dst_value;
    logic                  r_write_valid;

    always_ff @(posedge i_clk) begin
        if (i_ctl.s5) begin
            r_dst_x       <= w_wv ? w_qx[COORD_W-1:0] : '0;
            r_dst_y       <= w_wv ? w_qy[COORD_W-1:0] : '0;
            r_dst_z       <= w_wv ? w_qz[COORD_W-1:0] : '0;
            r_dst_index   <= w_wv ? w_idx[IDX_OUT_W-1:0] : '0;
            r_dst_value   <= w_wv ? i_val : '0;
            r_write_valid <= w_wv;
        end
    end

    assign o_dst_x       = r_dst_x;
    assign o_dst_y       = r_dst_y;
    assign o_dst_z       = r_dst_z;
    assign o_dst_index   = r_dst_index;
    assign o_dst_value   = r_dst_value;
    assign o_write_valid = r_write_valid;

endmodule

`default_nettype wire

FILE: rtl/voxel_axis_angle_rotate_core.sv
// Top level of the voxel axis-angle rotate core: handshake control and stage wiring.
// A result word passes the S1, S2, S3 and S4 registers and the S5 output register to the ports.
// Throughput: one word per cycle without a stall; five register stages, each with a valid bit.
// Reset (synchronous, active low): clears all stage valid bits and loads axis (0,0,1),
// cos 1.0, sin 0; o_ready is held low while reset is asserted.
`default_nettype none

module voxel_axis_angle_rotate_core
    import vaar_pkg::*;
(
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    // configuration write port
    input  wire logic                 i_cfg_we,
    input  wire logic [CFG_IDX_W-1:0] i_cfg_idx,
    input  wire logic [CFG_W-1:0]     i_cfg_data,
    // voxel in
    input  wire logic                 i_valid,
    output logic                      o_ready,
    input  t_coord                    i_src_x,
    input  t_coord                    i_src_y,
    input  t_coord                    i_src_z,
    input  t_val                      i_voxel_value,
    // write word out
    output logic                      o_valid,
    input  wire logic                 i_ready,
    output t_coord                    o_dst_x,
    output t_coord                    o_dst_y,
    output t_coord                    o_dst_z,
    output logic [IDX_OUT_W-1:0]      o_dst_index,
    output t_val                      o_dst_value,
    output logic                      o_write_valid
);

    // Pipeline map
    //   M1/M2 : matrix built from config registers, free running (vaar_matrix)
    //   S1    : capture voxel
    //   S2    : source bounds, nonzero flag
    //   S3    : 9 products coord * entry (reads matrix)
    //   S4    : row sums + 1/2 in Q.42
    //   S5    : round toward zero, destination bounds, index -> output register
    //
    // Matrix timing: config is to be written only with the pipe empty; the block itself
    // does not enforce this. A voxel accepted the cycle after a write passes S1 and S2
    // before the S2->S3 edge, by which point M2 already holds the new matrix. Same after reset.

    t_mat             w_mat;
    t_pipe_ctl        w_ctl;
    logic [NSTG-1:0]  r_v;       // stage valid bits, [0] = S1
    logic [NSTG-1:0]  w_rdy;     // stage can take a word this cycle

    // Ready ripples back from the output; a stage accepts when empty or
    // when the stage after it is moving, so bubbles collapse under a stall.
    always_comb begin
        w_rdy[NSTG-1] = !r_v[NSTG-1] || i_ready;
        for (int k = NSTG - 2; k >= 0; k--) begin
            w_rdy[k] = !r_v[k] || w_rdy[k+1];
        end
    end

    assign o_ready = w_rdy[0] && i_rst_n;

    // Data registers load only when a valid word actually moves in
    always_comb begin
        w_ctl.s1 = w_rdy[0] && i_valid && i_rst_n;
        w_ctl.s2 = w_rdy[1] && r_v[0];
        w_ctl.s3 = w_rdy[2] && r_v[1];
        w_ctl.s4 = w_rdy[3] && r_v[2];
        w_ctl.s5 = w_rdy[4] && r_v[3];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else begin
            if (w_rdy[0]) begin
                r_v[0] <= i_valid;
            end
            for (int k = 1; k < NSTG; k++) begin
                if (w_rdy[k]) begin
                    r_v[k] <= r_v[k-1];
                end
            end
        end
    end

    assign o_valid = r_v[NSTG-1];

    vaar_matrix u_matrix (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .o_mat      (w_mat)
    );

    t_acc [2:0] w_acc;
    logic       w_live;
    t_val       w_val;

    vaar_rotate u_rotate (
        .i_clk         (i_clk),
        .i_ctl         (w_ctl),
        .i_src_x       (i_src_x),
        .i_src_y       (i_src_y),
        .i_src_z       (i_src_z),
        .i_voxel_value (i_voxel_value),
        .i_mat         (w_mat),
        .o_acc         (w_acc),
        .o_live        (w_live),
        .o_val         (w_val)
    );

    vaar_place u_place (
        .i_clk         (i_clk),
        .i_ctl         (w_ctl),
        .i_acc         (w_acc),
        .i_live        (w_live),
        .i_val         (w_val),
        .o_dst_x       (o_dst_x),
        .o_dst_y       (o_dst_y),
        .o_dst_z       (o_dst_z),
        .o_dst_index   (o_dst_index),
        .o_dst_value   (o_dst_value),
        .o_write_valid (o_write_valid)
    );

endmodule

`default_nettype wire

FILE: rtl/vaar_checker.sv
// Port-level assertions for the rotate core, bound to the top level.
`default_nettype none

module vaar_checker
    import vaar_pkg::*;
(
    input wire logic                 i_clk,
    input wire logic                 i_rst_n,
    input wire logic                 o_ready,
    input wire logic                 o_valid,
    input wire logic                 i_ready,
    input t_coord                    o_dst_x,
    input t_coord                    o_dst_y,
    input t_coord                    o_dst_z,
    input wire logic [IDX_OUT_W-1:0] o_dst_index,
    input t_val                      o_dst_value,
    input wire logic                 o_write_valid
);

    // stalled word holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid && $stable({o_dst_x, o_dst_y, o_dst_z,
                                o_dst_index, o_dst_value, o_write_valid}))
        else $error("output word changed while stalled");

    // dropped write carries all-zero fields
    a_drop_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !o_write_valid |-> o_dst_x == '0 && o_dst_y == '0
                                      && o_dst_z == '0 && o_dst_index == '0
                                      && o_dst_value == '0)
        else $error("invalid write with nonzero fields");

    // an empty voxel is never written
    a_write_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_write_valid |-> o_dst_value != '0)
        else $error("write flagged for empty voxel");

    // reset empties the pipe
    a_rst_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("output valid right after reset");

    // no intake during reset
    a_rst_noready: assert property (@(posedge i_clk)
        !i_rst_n |-> !o_ready)
        else $error("ready asserted in reset");

endmodule

bind voxel_axis_angle_rotate_core vaar_checker u_vaar_checker (.*);

`default_nettype wire
